// ===== hdl/rpm_pkg.sv =====
// Shared types and constants for the rotation period monitor.
// No dependencies; used by rpm_div and rotation_period_monitor_unit.
package rpm_pkg;

  localparam int unsigned TICK_MS       = 20;
  localparam int unsigned TIMEOUT_TICKS = 10000;

  localparam int unsigned CNT_W    = 16;
  localparam int unsigned RATE_W   = 12;
  localparam int unsigned PROD_W   = CNT_W + 10;  // tick count times TICK_MS
  localparam int unsigned CMP_W    = CNT_W + 7;   // value times 101
  localparam int unsigned DIV_W    = 16;
  localparam int unsigned DIVIDEND = 60000;       // ms per minute
  localparam int unsigned RATE_MAX = (1 << RATE_W) - 1;

  typedef enum logic [2:0] {
    PS_IDLE    = 3'd0,
    PS_STARTED = 3'd1,
    PS_RUNNING = 3'd2,
    PS_SLOW    = 3'd3,
    PS_FAST    = 3'd4,
    PS_NORMAL  = 3'd5
  } pump_state_e;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_CMP_SLOW,
    SQ_CMP_FAST,
    SQ_DIV_START,
    SQ_DIV_WAIT,
    SQ_DONE
  } seq_e;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_res_t;

endpackage

// ===== hdl/rpm_div.sv =====
// Serial restoring divider: DIVIDEND / divisor, one quotient bit per cycle.
// Depends on rpm_pkg.
module rpm_div
  import rpm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] divisor_i,
  output div_res_t         res_o
);

  localparam int unsigned STEP_W = $clog2(DIV_W);

  logic              busy_q, busy_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [DIV_W-1:0]  rem_q, rem_d;
  logic [DIV_W-1:0]  quo_q, quo_d;
  logic [DIV_W-1:0]  dvs_q, dvs_d;
  logic              done_q, done_d;
  logic [DIV_W:0]    trial;
  logic              fits;

  assign trial = {rem_q, quo_q[DIV_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = '0;
      quo_d  = DIV_W'(DIVIDEND);
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      // remainder stays below the divisor, so the low bits hold it
      rem_d  = fits ? DIV_W'(trial - {1'b0, dvs_q}) : trial[DIV_W-1:0];
      quo_d  = {quo_q[DIV_W-2:0], fits};
      step_d = step_q + 1'b1;
      if (step_q == STEP_W'(DIV_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign res_o.done     = done_q;
  assign res_o.quotient = quo_q;

endmodule

// ===== hdl/rotation_period_monitor_unit.sv =====
// Rotation period monitor: tick/start sequencer, tolerance window and rate.
// Depends on rpm_pkg and rpm_div.
// A start, idle tick or tick without a measured period goes to hand-off; a
// measured period takes up to two window compares on the shared comparator
// (none before running), then the serial divider unless it is zero, then
// hand-off. Input is taken only after hand-off, while a result still waits.
// Reset: asynchronous, active low; monitor idle, counters and period cleared.
module rotation_period_monitor_unit
  import rpm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,   // expected_period
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [0] marker_level, rest zero
  input  logic        s_axis_tuser,  // [0] cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] pump_state, [18:3] period_ms, [34:19] period_delta,
  // [46:35] rate_per_minute, [47] alarm_underrun, [48] alarm_overrun,
  // [49] period_updated, rest zero
  output logic [55:0] m_axis_tdata
);

  seq_e              seq_q, seq_d;
  pump_state_e       run_q, run_d;
  logic [CNT_W-1:0]  tick_q, tick_d;
  logic [1:0]        rot_q, rot_d;
  logic              counting_q, counting_d;
  logic              prev_q, prev_d;
  logic [CNT_W-1:0]  period_q, period_d;
  logic [RATE_W-1:0] rate_q, rate_d;
  logic [CNT_W-1:0]  expected_q;
  logic              under_q, under_d;
  logic              over_q, over_d;
  logic              upd_q, upd_d;

  logic              out_valid_q, out_valid_d;
  logic [49:0]       out_q;
  logic              load;

  logic [CNT_W-1:0]  tick_inc;
  logic [PROD_W-1:0] prod;
  logic [CNT_W-1:0]  p_sat;
  logic              marker, edge_fall;
  logic [CMP_W-1:0]  p100, e101, e99, cmp_a, cmp_b;
  logic              cmp_gt;
  logic              div_start;
  div_res_t          div_res;

  rpm_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .divisor_i (period_q),
    .res_o     (div_res)
  );

  assign marker    = s_axis_tdata[0];
  assign edge_fall = !marker && prev_q;
  assign tick_inc  = (tick_q != {CNT_W{1'b1}}) ? tick_q + 1'b1 : tick_q;
  assign prod      = PROD_W'(tick_inc) * PROD_W'(TICK_MS);
  assign p_sat     = (prod > PROD_W'({CNT_W{1'b1}})) ? {CNT_W{1'b1}} : prod[CNT_W-1:0];

  assign p100 = CMP_W'(period_q) * CMP_W'(100);
  assign e101 = CMP_W'(expected_q) * CMP_W'(101);
  assign e99  = CMP_W'(expected_q) * CMP_W'(99);

  // one comparator serves both window edges
  always_comb begin
    if (seq_q == SQ_CMP_SLOW) begin
      cmp_a = p100;
      cmp_b = e101;
    end else begin
      cmp_a = e99;
      cmp_b = p100;
    end
  end
  assign cmp_gt = cmp_a > cmp_b;

  assign s_axis_tready = (seq_q == SQ_IDLE);
  assign load          = (seq_q == SQ_DONE) && (!out_valid_q || m_axis_tready);

  always_comb begin
    seq_d      = seq_q;
    run_d      = run_q;
    tick_d     = tick_q;
    rot_d      = rot_q;
    counting_d = counting_q;
    prev_d     = prev_q;
    period_d   = period_q;
    rate_d     = rate_q;
    under_d    = under_q;
    over_d     = over_q;
    upd_d      = upd_q;
    div_start  = 1'b0;
    unique case (seq_q)
      SQ_IDLE: begin
        if (s_axis_tvalid) begin
          under_d = 1'b0;
          over_d  = 1'b0;
          upd_d   = 1'b0;
          seq_d   = SQ_DONE;
          if (s_axis_tuser) begin
            run_d = PS_STARTED;
          end else if (run_q != PS_IDLE) begin
            tick_d  = tick_inc;
            under_d = tick_inc > CNT_W'(TIMEOUT_TICKS);
            prev_d  = marker;
            if (run_q == PS_STARTED && rot_q == 2'd3) begin
              run_d = PS_RUNNING;
            end
            if (edge_fall) begin
              tick_d = '0;
              if (!counting_q) begin
                counting_d = 1'b1;
              end else begin
                if (rot_q != 2'd3) rot_d = rot_q + 1'b1;
                period_d = p_sat;
                upd_d    = 1'b1;
                // window test only once running
                if (run_q == PS_STARTED && rot_q != 2'd3) begin
                  seq_d = SQ_DIV_START;
                end else begin
                  seq_d = SQ_CMP_SLOW;
                end
              end
            end
          end
        end
      end
      SQ_CMP_SLOW: begin
        if (cmp_gt) begin
          run_d   = PS_SLOW;
          under_d = 1'b1;
          seq_d   = SQ_DIV_START;
        end else begin
          seq_d = SQ_CMP_FAST;
        end
      end
      SQ_CMP_FAST: begin
        if (cmp_gt) begin
          run_d  = PS_FAST;
          over_d = 1'b1;
        end else begin
          run_d = PS_NORMAL;
        end
        seq_d = SQ_DIV_START;
      end
      SQ_DIV_START: begin
        if (period_q == '0) begin
          rate_d = '0;
          seq_d  = SQ_DONE;
        end else begin
          div_start = 1'b1;
          seq_d     = SQ_DIV_WAIT;
        end
      end
      SQ_DIV_WAIT: begin
        if (div_res.done) begin
          rate_d = (div_res.quotient > DIV_W'(RATE_MAX)) ? RATE_W'(RATE_MAX)
                                                         : div_res.quotient[RATE_W-1:0];
          seq_d  = SQ_DONE;
        end
      end
      SQ_DONE: begin
        if (load) seq_d = SQ_IDLE;
      end
      default: seq_d = SQ_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q       <= SQ_IDLE;
      run_q       <= PS_IDLE;
      tick_q      <= '0;
      rot_q       <= '0;
      counting_q  <= 1'b0;
      prev_q      <= 1'b1;
      period_q    <= '0;
      rate_q      <= '0;
      expected_q  <= '0;
      under_q     <= 1'b0;
      over_q      <= 1'b0;
      upd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      seq_q       <= seq_d;
      run_q       <= run_d;
      tick_q      <= tick_d;
      rot_q       <= rot_d;
      counting_q  <= counting_d;
      prev_q      <= prev_d;
      period_q    <= period_d;
      rate_q      <= rate_d;
      under_q     <= under_d;
      over_q      <= over_d;
      upd_q       <= upd_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) expected_q <= cfg_wdata_i;
    end
  end

  // result word register
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= {upd_q, over_q, under_q, rate_q, period_q - expected_q, period_q, run_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_q};

endmodule
